// ----- rtl/core/ray_segment_nearest_hit_unit_macros.svh -----
// Assertion macros for the ray segment nearest hit unit.
// Taken in by the checker file; depends on nothing else.
`ifndef RAY_SEGMENT_NEAREST_HIT_UNIT_MACROS_SVH
`define RAY_SEGMENT_NEAREST_HIT_UNIT_MACROS_SVH

// Check a property while reset is released.
`define RSNH_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define RSNH_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/rsnh_pkg.sv -----
// Shared types and constants of the ray segment nearest hit unit.
// No dependencies; used by every module of the block.
`default_nettype none

package rsnh_pkg;

    // Fixed field widths
    localparam int SLOT_W    = 6;
    localparam int DIR_W     = 16;
    localparam int DIST_W    = 23;
    localparam int ANG_W     = 16;
    localparam int WNUM_W    = 6;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 23;
    localparam int CNT_CFG_W = 7;
    localparam int LIM_W     = 20;

    // Division: quotient bits, fraction bits, integer-part bits
    localparam int QUOT_BITS = DIST_W;
    localparam int FRAC_BITS = 14;
    localparam int PRE_BITS  = QUOT_BITS - FRAC_BITS;

    // Register reset values
    localparam logic [DIST_W-1:0]    MAX_DIST_RST = 23'd262144;
    localparam logic [CNT_CFG_W-1:0] WALL_CNT_RST = 7'd0;
    localparam logic [LIM_W-1:0]     DEG_LIM_RST  = 20'd671;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WALL_CNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEG_LIM  = 2'd2;

    // Item kinds on tuser
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_CAST = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_DIFF,
        ST_MUL,
        ST_SUB,
        ST_TEST,
        ST_DIV,
        ST_FIN_MUL,
        ST_FIN_OUT
    } t_state;

    // Divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

`default_nettype wire

// ----- rtl/core/rsnh_div.sv -----
// Restoring divider, one quotient bit per cycle: floor(num * 2^14 / den).
// Depends on rsnh_pkg. Caller guarantees the quotient fits in QUOT_BITS.
`default_nettype none

module rsnh_div #(
    parameter int NW = 51,
    parameter int DW = 42
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_start,
    input  wire [NW-1:0]                        i_num,
    input  wire [DW-1:0]                        i_den,
    output rsnh_pkg::t_div_stat                 o_stat,
    output logic [rsnh_pkg::QUOT_BITS-1:0]      o_quot
);

    localparam int QB = rsnh_pkg::QUOT_BITS;
    localparam int CW = $clog2(QB + 1);

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [DW-1:0]     r_rem;
    logic [DW-1:0]     r_den;
    logic [QB-1:0]     r_sh;
    logic [QB-1:0]     r_q;

    logic [DW:0]       trial;
    logic              ge;

    // One trial subtraction
    always_comb begin
        trial = {r_rem, r_sh[QB-1]};
        ge    = trial >= {1'b0, r_den};
    end

    // Control: count steps, pulse done after the last
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(QB - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: load operands, then shift in one bit a cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= DW'(i_num >> rsnh_pkg::PRE_BITS);
            r_den <= i_den;
            r_sh  <= {i_num[rsnh_pkg::PRE_BITS-1:0], {rsnh_pkg::FRAC_BITS{1'b0}}};
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? DW'(trial - {1'b0, r_den}) : DW'(trial);
            r_sh  <= {r_sh[QB-2:0], 1'b0};
            r_q   <= {r_q[QB-2:0], ge};
        end
    end

    assign o_stat = {r_busy, r_done};
    assign o_quot = r_q;

endmodule

`default_nettype wire

// ----- rtl/core/ray_segment_nearest_hit_unit.sv -----
// Ray segment nearest hit unit: wall table memory, per-wall cross-product
// test and nearest-hit search. Depends on rsnh_pkg and rsnh_div.
//
// Usage:
//   Input stream s_axis: tuser selects the word kind. A load word (tuser 0)
//   writes one wall into the table in the cycle it is taken. A cast word
//   (tuser 1) tests the ray against walls 0 .. wall_count-1, wall_count
//   capped at MAX_WALLS, and returns one result word on m_axis: hit flag,
//   hit or far point, distance, angle tag and wall number.
//   Configuration: i_cfg_we with i_cfg_index / i_cfg_data writes the range
//   limit, wall_count or degenerate_limit; write only while idle.
//   Steps: a load word leaves the unit idle. In a cast, each wall is one
//   table read, one subtract, one multiply, one combine and one test
//   step; a wall that passes the range tests then goes through the
//   bit-serial divider (23 steps each). One item is in work at a time.
//   Reset: registers return to their reset values; the table is not
//   cleared and each entry must be loaded before a cast reads it.
//   Stall: a finished result holds on m_axis until taken; the unit takes
//   the next input word meanwhile and only waits at the end of the next
//   cast if the result is still not taken.
`default_nettype none

module ray_segment_nearest_hit_unit #(
    parameter int MAX_WALLS  = 64,
    parameter int COORD_BITS = 24,
    localparam int IN_W      = ((6 * COORD_BITS + 54 + 7) / 8) * 8,
    localparam int OUT_W     = ((2 * COORD_BITS + 46 + 7) / 8) * 8
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // config write port
    input  wire                              i_cfg_we,
    input  wire [rsnh_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire [rsnh_pkg::CFG_W-1:0]        i_cfg_data,
    // input stream
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata, low bit up: wall_slot, wall_start_x, wall_start_y, wall_end_x,
    // wall_end_y, origin_x, origin_y, dir_x, dir_y, angle_tag
    input  wire [IN_W-1:0]                   s_axis_tdata,
    // tuser: func
    input  wire [0:0]                        s_axis_tuser,
    // output stream
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    // tdata, low bit up: hit, point_x, point_y, distance, angle_out,
    // wall_number
    output logic [OUT_W-1:0]                 m_axis_tdata
);

    localparam int C    = COORD_BITS;
    localparam int W    = C + 1;
    localparam int AW   = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;
    localparam int CW   = $clog2(MAX_WALLS + 1);
    localparam int DRW  = rsnh_pkg::DIR_W;
    localparam int DSW  = rsnh_pkg::DIST_W;
    localparam int PD   = W + DRW;
    localparam int DD   = PD + 1;
    localparam int DX   = DD + 1;
    localparam int NP   = 2 * W;
    localparam int NT   = NP + 1;
    localparam int NTX  = NT + 1;
    localparam int CM   = (NTX > DX) ? NTX : DX;
    localparam int PW   = DRW + DSW + 1;
    localparam int SHW  = PW - rsnh_pkg::FRAC_BITS;
    localparam int SW   = ((C > SHW) ? C : SHW) + 1;
    localparam int SLW  = rsnh_pkg::SLOT_W;
    localparam int OUT_BITS = 1 + 2 * C + DSW + rsnh_pkg::ANG_W + rsnh_pkg::WNUM_W;

    // input field offsets
    localparam int O_SX  = SLW;
    localparam int O_SY  = O_SX + C;
    localparam int O_EX  = O_SY + C;
    localparam int O_EY  = O_EX + C;
    localparam int O_OX  = O_EY + C;
    localparam int O_OY  = O_OX + C;
    localparam int O_DX  = O_OY + C;
    localparam int O_DY  = O_DX + DRW;
    localparam int O_ANG = O_DY + DRW;

    localparam logic signed [SW-1:0] SAT_HI = {{(SW - C + 1){1'b0}}, {(C - 1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_LO = {{(SW - C + 1){1'b1}}, {(C - 1){1'b0}}};

    // configuration
    logic [DSW-1:0]                      r_max_dist;
    logic [rsnh_pkg::CNT_CFG_W-1:0]      r_wall_cnt;
    logic [rsnh_pkg::LIM_W-1:0]          r_deg_lim;

    // sequencer
    rsnh_pkg::t_state r_state;
    rsnh_pkg::t_state n_state;

    // wall table
    logic [4*C-1:0]  r_mem [MAX_WALLS];
    logic [4*C-1:0]  r_rd_data;

    // ray and search state
    logic signed [C-1:0]    r_ox, r_oy;
    logic signed [DRW-1:0]  r_dx, r_dy;
    logic [rsnh_pkg::ANG_W-1:0] r_ang;
    logic [CW-1:0]          r_idx;
    logic [CW-1:0]          r_count;
    logic [DSW-1:0]         r_best;
    logic                   r_found;
    logic [AW-1:0]          r_best_wall;

    // per-wall pipeline registers
    logic signed [W-1:0]    r_sgx, r_sgy, r_ofx, r_ofy;
    logic signed [PD-1:0]   r_p_d1, r_p_d2, r_p_u1, r_p_u2;
    logic signed [NP-1:0]   r_p_n1, r_p_n2;
    logic signed [DD-1:0]   r_d, r_nu;
    logic signed [NT-1:0]   r_nt;

    // final point
    logic signed [PW-1:0]   r_pxp, r_pyp;

    // output register
    logic                   r_out_valid;
    logic [OUT_BITS-1:0]    r_out;

    // decoded input
    logic              in_acc;
    logic              in_cast;
    logic [SLW-1:0]    in_slot;
    logic [31:0]       slot_ext;
    logic              slot_ok;
    logic [31:0]       cnt_ext;
    logic [CW-1:0]     cnt_lim;

    // test stage
    logic signed [DX-1:0]   d_x, df, nu_x, nuf, lim_x;
    logic signed [NTX-1:0]  nt_x, ntf;
    logic                   d_neg;
    logic                   skip;
    logic                   far;
    logic                   div_start;
    logic                   last_wall;
    logic                   out_free;

    rsnh_pkg::t_div_stat    div_stat;
    logic [DSW-1:0]         div_quot;

    // final point sums
    logic signed [SW-1:0]   sum_x, sum_y;
    logic signed [C-1:0]    sat_x, sat_y;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign in_cast  = s_axis_tuser[0] == rsnh_pkg::FUNC_CAST;
    assign in_slot  = s_axis_tdata[SLW-1:0];
    assign slot_ext = 32'(in_slot);
    assign slot_ok  = slot_ext < 32'(MAX_WALLS);
    assign cnt_ext  = 32'(r_wall_cnt);
    assign cnt_lim  = (cnt_ext > 32'(MAX_WALLS)) ? CW'(MAX_WALLS) : CW'(cnt_ext);
    assign last_wall = (r_idx + 1'b1) == r_count;
    assign out_free  = !r_out_valid || m_axis_tready;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_dist <= rsnh_pkg::MAX_DIST_RST;
            r_wall_cnt <= rsnh_pkg::WALL_CNT_RST;
            r_deg_lim  <= rsnh_pkg::DEG_LIM_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rsnh_pkg::CFG_MAX_DIST: r_max_dist <= i_cfg_data[DSW-1:0];
                rsnh_pkg::CFG_WALL_CNT: r_wall_cnt <= i_cfg_data[rsnh_pkg::CNT_CFG_W-1:0];
                rsnh_pkg::CFG_DEG_LIM:  r_deg_lim  <= i_cfg_data[rsnh_pkg::LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Wall table: write on load, read the current index every cycle
    always_ff @(posedge i_clk) begin
        if (in_acc && !in_cast && slot_ok) begin
            r_mem[slot_ext[AW-1:0]] <= s_axis_tdata[O_OX-1:O_SX];
        end
        r_rd_data <= r_mem[r_idx[AW-1:0]];
    end

    // Test stage: fold the sign of the denominator, check ranges
    always_comb begin
        d_x   = DX'(r_d);
        nu_x  = DX'(r_nu);
        nt_x  = NTX'(r_nt);
        d_neg = r_d[DD-1];
        df    = d_neg ? -d_x : d_x;
        nuf   = d_neg ? -nu_x : nu_x;
        ntf   = d_neg ? -nt_x : nt_x;
        lim_x = $signed(DX'(r_deg_lim));
        far   = CM'(ntf >>> rsnh_pkg::PRE_BITS) >= CM'(df);
        skip  = (r_d == '0) || (df < lim_x) || (ntf < 0) || (nuf < 0) || (nuf > df) || far;
        div_start = (r_state == rsnh_pkg::ST_TEST) && !skip;
    end

    rsnh_div #(
        .NW (NT),
        .DW (DD)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (ntf[NT-1:0]),
        .i_den   (df[DD-1:0]),
        .o_stat  (div_stat),
        .o_quot  (div_quot)
    );

    // Sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rsnh_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and input ready
    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        unique case (r_state)
            rsnh_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid && in_cast) begin
                    n_state = (cnt_lim == '0) ? rsnh_pkg::ST_FIN_MUL : rsnh_pkg::ST_READ;
                end
            end
            rsnh_pkg::ST_READ: n_state = rsnh_pkg::ST_DIFF;
            rsnh_pkg::ST_DIFF: n_state = rsnh_pkg::ST_MUL;
            rsnh_pkg::ST_MUL:  n_state = rsnh_pkg::ST_SUB;
            rsnh_pkg::ST_SUB:  n_state = rsnh_pkg::ST_TEST;
            rsnh_pkg::ST_TEST: begin
                if (!skip) begin
                    n_state = rsnh_pkg::ST_DIV;
                end else begin
                    n_state = last_wall ? rsnh_pkg::ST_FIN_MUL : rsnh_pkg::ST_READ;
                end
            end
            rsnh_pkg::ST_DIV: begin
                if (div_stat.done) begin
                    n_state = last_wall ? rsnh_pkg::ST_FIN_MUL : rsnh_pkg::ST_READ;
                end
            end
            rsnh_pkg::ST_FIN_MUL: n_state = rsnh_pkg::ST_FIN_OUT;
            rsnh_pkg::ST_FIN_OUT: begin
                if (out_free) begin
                    n_state = rsnh_pkg::ST_IDLE;
                end
            end
            default: n_state = rsnh_pkg::ST_IDLE;
        endcase
    end

    // Search control: index and best hit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_found <= 1'b0;
        end else begin
            if (r_state == rsnh_pkg::ST_IDLE && in_acc && in_cast) begin
                r_idx   <= '0;
                r_found <= 1'b0;
            end else if ((r_state == rsnh_pkg::ST_TEST && skip) ||
                         (r_state == rsnh_pkg::ST_DIV && div_stat.done)) begin
                r_idx <= r_idx + 1'b1;
            end
            if (r_state == rsnh_pkg::ST_DIV && div_stat.done && div_quot < r_best) begin
                r_found <= 1'b1;
            end
        end
    end

    // Ray latch and best distance
    always_ff @(posedge i_clk) begin
        if (r_state == rsnh_pkg::ST_IDLE && in_acc && in_cast) begin
            r_ox    <= $signed(s_axis_tdata[O_OY-1:O_OX]);
            r_oy    <= $signed(s_axis_tdata[O_DX-1:O_OY]);
            r_dx    <= $signed(s_axis_tdata[O_DY-1:O_DX]);
            r_dy    <= $signed(s_axis_tdata[O_ANG-1:O_DY]);
            r_ang   <= s_axis_tdata[O_ANG+rsnh_pkg::ANG_W-1:O_ANG];
            r_count <= cnt_lim;
            r_best  <= r_max_dist;
            r_best_wall <= '0;
        end else if (r_state == rsnh_pkg::ST_DIV && div_stat.done && div_quot < r_best) begin
            r_best      <= div_quot;
            r_best_wall <= r_idx[AW-1:0];
        end
    end

    // Per-wall pipeline: differences, products, cross products; final point products
    always_ff @(posedge i_clk) begin
        logic signed [C-1:0] sx, sy, ex, ey;
        sx = $signed(r_rd_data[C-1:0]);
        sy = $signed(r_rd_data[2*C-1:C]);
        ex = $signed(r_rd_data[3*C-1:2*C]);
        ey = $signed(r_rd_data[4*C-1:3*C]);
        if (r_state == rsnh_pkg::ST_DIFF) begin
            r_sgx <= W'(ex) - W'(sx);
            r_sgy <= W'(ey) - W'(sy);
            r_ofx <= W'(sx) - W'(r_ox);
            r_ofy <= W'(sy) - W'(r_oy);
        end
        if (r_state == rsnh_pkg::ST_MUL) begin
            r_p_d1 <= r_dx * r_sgy;
            r_p_d2 <= r_dy * r_sgx;
            r_p_n1 <= r_ofx * r_sgy;
            r_p_n2 <= r_ofy * r_sgx;
            r_p_u1 <= r_ofx * r_dy;
            r_p_u2 <= r_ofy * r_dx;
        end
        if (r_state == rsnh_pkg::ST_SUB) begin
            r_d  <= DD'(r_p_d1) - DD'(r_p_d2);
            r_nt <= NT'(r_p_n1) - NT'(r_p_n2);
            r_nu <= DD'(r_p_u1) - DD'(r_p_u2);
        end
        if (r_state == rsnh_pkg::ST_FIN_MUL) begin
            r_pxp <= r_dx * $signed({1'b0, r_best});
            r_pyp <= r_dy * $signed({1'b0, r_best});
        end
    end

    // Final point: origin plus floored step, saturated
    always_comb begin
        sum_x = SW'(r_ox) + SW'(r_pxp >>> rsnh_pkg::FRAC_BITS);
        sum_y = SW'(r_oy) + SW'(r_pyp >>> rsnh_pkg::FRAC_BITS);
        priority if (sum_x > SAT_HI) sat_x = SAT_HI[C-1:0];
        else if (sum_x < SAT_LO)     sat_x = SAT_LO[C-1:0];
        else                         sat_x = sum_x[C-1:0];
        priority if (sum_y > SAT_HI) sat_y = SAT_HI[C-1:0];
        else if (sum_y < SAT_LO)     sat_y = SAT_LO[C-1:0];
        else                         sat_y = sum_y[C-1:0];
    end

    // Output register: load the result word, hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == rsnh_pkg::ST_FIN_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == rsnh_pkg::ST_FIN_OUT && out_free) begin
            r_out <= {rsnh_pkg::WNUM_W'(32'(r_best_wall)) & {rsnh_pkg::WNUM_W{r_found}},
                      r_ang, r_best, sat_y, sat_x, r_found};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'(r_out);

endmodule

`default_nettype wire

// ----- rtl/core/rsnh_checker.sv -----
// Port-level checks of the ray segment nearest hit unit, bound to the top.
// Depends on rsnh_pkg and the assertion macro header.
`default_nettype none
`include "ray_segment_nearest_hit_unit_macros.svh"

module rsnh_checker #(
    parameter int OUT_W = 96
) (
    input wire              i_clk,
    input wire              i_rst_n,
    input wire              s_axis_tvalid,
    input wire              s_axis_tready,
    input wire [0:0]        s_axis_tuser,
    input wire              m_axis_tvalid,
    input wire              m_axis_tready,
    input wire [OUT_W-1:0]  m_axis_tdata
);

    logic cast_acc;
    logic load_acc;

    assign cast_acc = s_axis_tvalid && s_axis_tready &&
                      (s_axis_tuser[0] == rsnh_pkg::FUNC_CAST);
    assign load_acc = s_axis_tvalid && s_axis_tready &&
                      (s_axis_tuser[0] == rsnh_pkg::FUNC_LOAD);

    // Reset drops any pending result
    `RSNH_ASSERT_ALWAYS(a_rst_out, i_clk, !i_rst_n |=> !m_axis_tvalid, "result valid after reset")

    // A stalled result holds
    `RSNH_ASSERT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

    // A cast blocks input and cannot answer in the next cycle
    `RSNH_ASSERT(a_cast_busy, i_clk, i_rst_n, cast_acc |=> !s_axis_tready && !$rose(m_axis_tvalid), "cast did not occupy unit")

    // A load leaves the unit ready for input and raises no result
    `RSNH_ASSERT(a_load_idle, i_clk, i_rst_n, load_acc |=> s_axis_tready && !$rose(m_axis_tvalid), "load not single cycle")

endmodule

bind ray_segment_nearest_hit_unit rsnh_checker #(
    .OUT_W (OUT_W)
) u_rsnh_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
